// ===== src/rscr_pkg.sv =====
package rscr_pkg;

    // Coefficients per polynomial
    localparam int unsigned NUM_COEFFS = 4096;

    localparam int LOW_W      = 64;
    localparam int HIGH_W     = 17;
    localparam int CAND_W     = LOW_W + HIGH_W;
    localparam int MOD_W      = 32;
    localparam int IDX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COUNT_W    = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
    localparam int BIT_CNT_W  = $clog2(CAND_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_LOW     = 3'd0,
        CFG_Q_HIGH    = 3'd1,
        CFG_MODULUS_A = 3'd2,
        CFG_MODULUS_B = 3'd3,
        CFG_MODULUS_C = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        LANE_A,
        LANE_B,
        LANE_C
    } lane_t;

endpackage

// ===== src/rscr_cand_if.sv =====
interface rscr_cand_if;
    import rscr_pkg::*;

    logic              valid;
    logic              ready;
    logic [LOW_W-1:0]  cand_low;
    logic [HIGH_W-1:0] cand_high;

    modport source (output valid, output cand_low, output cand_high, input ready);
    modport sink   (input valid, input cand_low, input cand_high, output ready);

endinterface

// ===== src/rscr_res_if.sv =====
interface rscr_res_if;
    import rscr_pkg::*;

    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] residue_a;
    logic [MOD_W-1:0] residue_b;
    logic [MOD_W-1:0] residue_c;
    logic [IDX_W-1:0] coeff_index;
    logic             last;

    modport source (output valid, output residue_a, output residue_b, output residue_c,
                    output coeff_index, output last, input ready);
    modport sink   (input valid, input residue_a, input residue_b, input residue_c,
                    input coeff_index, input last, output ready);

endinterface

// ===== src/rscr_mod_unit.sv =====
// Bit-serial restoring remainder: one dividend bit per step, MSB first.
module rscr_mod_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      step,
    input  logic                      din,
    input  logic [rscr_pkg::MOD_W-1:0] modulus,
    output logic [rscr_pkg::MOD_W-1:0] step_rem
);
    import rscr_pkg::*;

    logic [MOD_W-1:0] rem_reg;
    logic [MOD_W-1:0] rem_next;
    logic [MOD_W:0]   shifted;
    logic [MOD_W:0]   diff;

    // rem < modulus holds before the step, so shifted < 2*modulus
    always_comb
    begin
        shifted = {rem_reg, din};
        diff    = shifted - {1'b0, modulus};
        if (shifted >= {1'b0, modulus})
        begin
            step_rem = diff[MOD_W-1:0];
        end
        else
        begin
            step_rem = shifted[MOD_W-1:0];
        end
    end

    always_comb
    begin
        if (clear)
        begin
            rem_next = '0;
        end
        else if (step)
        begin
            rem_next = step_rem;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== src/rejection_sample_crt_reduce_unit.sv =====
// Rejection sampler with three-way residue reduction. Each candidate word is
// compared against Q in its accept cycle; a candidate at or above Q is dropped
// and the unit is ready again on the next cycle. A kept candidate is reduced by
// modulus_a, modulus_b and modulus_c in turn on one shared bit-serial remainder
// unit, one candidate bit per cycle; the unit takes no new candidate until all
// three residues are done and the result has moved into the output register,
// which waits while the previous result still sits unread there. The result word
// carries the coefficient index and a last flag on the final coefficient of
// each polynomial; a modulus of zero yields a zero residue.
module rejection_sample_crt_reduce_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rscr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rscr_pkg::CFG_DATA_W-1:0] cfg_data,
    rscr_cand_if.sink                       cand,
    rscr_res_if.source                      res
);
    import rscr_pkg::*;

    logic [LOW_W-1:0]     q_low_reg,     q_low_next;
    logic [HIGH_W-1:0]    q_high_reg,    q_high_next;
    logic [MOD_W-1:0]     modulus_a_reg, modulus_a_next;
    logic [MOD_W-1:0]     modulus_b_reg, modulus_b_next;
    logic [MOD_W-1:0]     modulus_c_reg, modulus_c_next;

    state_t               state_reg,     state_next;
    lane_t                lane_reg,      lane_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg,   bit_cnt_next;
    logic [CAND_W-1:0]    cand_reg,      cand_next;
    logic [COUNT_W-1:0]   count_reg,     count_next;
    logic [IDX_W-1:0]     idx_reg,       idx_next;
    logic                 last_reg,      last_next;
    logic [MOD_W-1:0]     res_a_reg,     res_a_next;
    logic [MOD_W-1:0]     res_b_reg,     res_b_next;
    logic [MOD_W-1:0]     res_c_reg,     res_c_next;

    logic                 out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]     out_a_reg,     out_a_next;
    logic [MOD_W-1:0]     out_b_reg,     out_b_next;
    logic [MOD_W-1:0]     out_c_reg,     out_c_next;
    logic [IDX_W-1:0]     out_idx_reg,   out_idx_next;
    logic                 out_last_reg,  out_last_next;

    logic                 in_take;
    logic                 below;
    logic                 is_last;
    logic                 unit_clear;
    logic                 unit_step;
    logic [MOD_W-1:0]     mod_sel;
    logic [MOD_W-1:0]     step_rem;
    logic [MOD_W-1:0]     lane_res;
    logic                 lane_end;
    logic                 out_load;

    rscr_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (unit_clear),
        .step     (unit_step),
        .din      (cand_reg[CAND_W-1]),
        .modulus  (mod_sel),
        .step_rem (step_rem)
    );

    // configuration writes
    always_comb
    begin
        q_low_next     = q_low_reg;
        q_high_next    = q_high_reg;
        modulus_a_next = modulus_a_reg;
        modulus_b_next = modulus_b_reg;
        modulus_c_next = modulus_c_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_Q_LOW:     q_low_next     = cfg_data;
                CFG_Q_HIGH:    q_high_next    = cfg_data[HIGH_W-1:0];
                CFG_MODULUS_A: modulus_a_next = cfg_data[MOD_W-1:0];
                CFG_MODULUS_B: modulus_b_next = cfg_data[MOD_W-1:0];
                CFG_MODULUS_C: modulus_c_next = cfg_data[MOD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (lane_reg)
            LANE_A:  mod_sel = modulus_a_reg;
            LANE_B:  mod_sel = modulus_b_reg;
            LANE_C:  mod_sel = modulus_c_reg;
            default: mod_sel = modulus_c_reg;
        endcase
    end

    assign below    = {cand.cand_high, cand.cand_low} < {q_high_reg, q_low_reg};
    assign is_last  = (count_reg == COUNT_W'(NUM_COEFFS - 1));
    assign in_take  = cand.valid && cand.ready;
    assign lane_end = (bit_cnt_reg == BIT_CNT_W'(CAND_W - 1));
    assign lane_res = (mod_sel == '0) ? '0 : step_rem;
    assign cand.ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        lane_next    = lane_reg;
        bit_cnt_next = bit_cnt_reg;
        cand_next    = cand_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        res_a_next   = res_a_reg;
        res_b_next   = res_b_reg;
        res_c_next   = res_c_reg;
        unit_clear   = 1'b0;
        unit_step    = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && below)
                begin
                    cand_next    = {cand.cand_high, cand.cand_low};
                    idx_next     = IDX_W'(count_reg);
                    last_next    = is_last;
                    count_next   = is_last ? '0 : count_reg + 1'b1;
                    lane_next    = LANE_A;
                    bit_cnt_next = '0;
                    unit_clear   = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unit_step = 1'b1;
                // rotate so the full candidate is back in place for the next lane
                cand_next = {cand_reg[CAND_W-2:0], cand_reg[CAND_W-1]};
                if (lane_end)
                begin
                    unit_clear   = 1'b1;
                    bit_cnt_next = '0;
                    unique case (lane_reg)
                        LANE_A:
                        begin
                            res_a_next = lane_res;
                            lane_next  = LANE_B;
                        end
                        LANE_B:
                        begin
                            res_b_next = lane_res;
                            lane_next  = LANE_C;
                        end
                        default:
                        begin
                            res_c_next = lane_res;
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_a_next    = out_a_reg;
        out_b_next    = out_b_reg;
        out_c_next    = out_c_reg;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_a_next     = res_a_reg;
            out_b_next     = res_b_reg;
            out_c_next     = res_c_reg;
            out_idx_next   = idx_reg;
            out_last_next  = last_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.residue_a   = out_a_reg;
    assign res.residue_b   = out_b_reg;
    assign res.residue_c   = out_c_reg;
    assign res.coeff_index = out_idx_reg;
    assign res.last        = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_low_reg     <= '0;
            q_high_reg    <= '0;
            modulus_a_reg <= MOD_W'(1);
            modulus_b_reg <= MOD_W'(1);
            modulus_c_reg <= MOD_W'(1);
            state_reg     <= ST_IDLE;
            lane_reg      <= LANE_A;
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_low_reg     <= q_low_next;
            q_high_reg    <= q_high_next;
            modulus_a_reg <= modulus_a_next;
            modulus_b_reg <= modulus_b_next;
            modulus_c_reg <= modulus_c_next;
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            bit_cnt_reg   <= bit_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        res_a_reg    <= res_a_next;
        res_b_reg    <= res_b_next;
        res_c_reg    <= res_c_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_c_reg    <= out_c_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== tb/rscr_residue_checker.sv =====
`timescale 1ns / 1ps

module rscr_residue_checker
    import rscr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rscr_cand_if                  cand,
    rscr_res_if                   res,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [MOD_W-1:0] residue_a;
        logic [MOD_W-1:0] residue_b;
        logic [MOD_W-1:0] residue_c;
        logic [IDX_W-1:0] coeff_index;
        logic             last;
    } residue_word_t;

    logic [LOW_W-1:0]  q_low_r;
    logic [HIGH_W-1:0] q_high_r;
    logic [MOD_W-1:0]  mod_a_r;
    logic [MOD_W-1:0]  mod_b_r;
    logic [MOD_W-1:0]  mod_c_r;
    int unsigned       coeff_count;
    residue_word_t     residue_words_q[$];
    int                fail_count   = 0;

    assign errors   = fail_count;
    assign pending  = residue_words_q.size();

    function automatic logic [MOD_W-1:0] reduce_residue(input logic [CAND_W-1:0] value,
                                                        input logic [MOD_W-1:0]  m);
        logic [CAND_W-1:0] r;
        if (m == '0)
            return '0;
        r = value % {{(CAND_W-MOD_W){1'b0}}, m};
        return r[MOD_W-1:0];
    endfunction

    task automatic report_failure(input string msg);
        if (fail_count < 100)
            $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    // Candidates at or above Q are dropped; the rest get an index in the polynomial
    task automatic predict_word(input logic [CAND_W-1:0] value);
        residue_word_t w;
        if (value >= {q_high_r, q_low_r})
            return;
        if (coeff_count >= NUM_COEFFS)
            coeff_count = 0;
        w.residue_a   = reduce_residue(value, mod_a_r);
        w.residue_b   = reduce_residue(value, mod_b_r);
        w.residue_c   = reduce_residue(value, mod_c_r);
        w.coeff_index = coeff_count[IDX_W-1:0];
        w.last        = (coeff_count == NUM_COEFFS - 1);
        coeff_count   = w.last ? 0 : coeff_count + 1;
        residue_words_q.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        residue_word_t want;
        if (!rst_n)
        begin
            q_low_r     = '0;
            q_high_r    = '0;
            mod_a_r     = 32'd1;
            mod_b_r     = 32'd1;
            mod_c_r     = 32'd1;
            coeff_count = 0;
            residue_words_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_Q_LOW:     q_low_r = cfg_data;
                    CFG_Q_HIGH:    q_high_r = cfg_data[HIGH_W-1:0];
                    CFG_MODULUS_A: mod_a_r = cfg_data[MOD_W-1:0];
                    CFG_MODULUS_B: mod_b_r = cfg_data[MOD_W-1:0];
                    CFG_MODULUS_C: mod_c_r = cfg_data[MOD_W-1:0];
                    default: ;
                endcase
            end

            if (res.valid && res.ready)
            begin
                if (residue_words_q.size() == 0)
                begin
                    report_failure($sformatf("result word with nothing expected, coeff_index %0d",
                                             res.coeff_index));
                end
                else
                begin
                    want = residue_words_q.pop_front();
                    if (res.residue_a !== want.residue_a)
                        report_failure($sformatf("residue_a at coeff %0d: got %h, expected %h",
                                                 want.coeff_index, res.residue_a, want.residue_a));
                    if (res.residue_b !== want.residue_b)
                        report_failure($sformatf("residue_b at coeff %0d: got %h, expected %h",
                                                 want.coeff_index, res.residue_b, want.residue_b));
                    if (res.residue_c !== want.residue_c)
                        report_failure($sformatf("residue_c at coeff %0d: got %h, expected %h",
                                                 want.coeff_index, res.residue_c, want.residue_c));
                    if (res.coeff_index !== want.coeff_index)
                        report_failure($sformatf("coeff_index: got %0d, expected %0d",
                                                 res.coeff_index, want.coeff_index));
                    if (res.last !== want.last)
                        report_failure($sformatf("last at coeff %0d: got %b, expected %b",
                                                 want.coeff_index, res.last, want.last));
                end
            end

            if (cand.valid && cand.ready)
                predict_word({cand.cand_high, cand.cand_low});
        end
    end

endmodule

// ===== tb/tb_rejection_sample_crt_reduce_unit.sv =====
`timescale 1ns / 1ps

module tb_rejection_sample_crt_reduce_unit;
    import rscr_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 12_000_000;
    localparam int RANDOM_ITEMS  = 1600;

    localparam logic [CAND_W-1:0] CAND_MAX = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rscr_cand_if cand_if();
    rscr_res_if  res_if();

    int                errors;
    int                pending;
    int                cycle_count   = 0;
    int                burst_left    = 0;
    int                random_items  = 0;
    bit                long_hold_req = 1'b0;
    logic [CAND_W-1:0] q_value;

    rejection_sample_crt_reduce_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cand      (cand_if),
        .res       (res_if)
    );

    rscr_residue_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cand      (cand_if),
        .res       (res_if),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [CAND_W-1:0] random_word();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return bits[CAND_W-1:0];
    endfunction

    function automatic logic [MOD_W-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(2, 16);
            4:       return 32'd1 << $urandom_range(1, 31);
            5:       return 32'hFFFF_FFFF - $urandom_range(1, 8);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CAND_W-1:0] pick_q();
        logic [CAND_W-1:0] q;
        case ($urandom_range(0, 3))
            0: q = CAND_MAX;
            1: q = random_word();
            2:
            begin
                q = '0;
                q[31:0] = $urandom();
            end
            default:
            begin
                q = random_word();
                q[LOW_W-1:0] = '0;
            end
        endcase
        if (q == '0)
            q = 1;
        return q;
    endfunction

    // Mostly words below Q, some right on the boundary, some raw noise
    function automatic logic [CAND_W-1:0] pick_candidate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return random_word() % q_value;
        else if (r < 91)
            return q_value - 1;
        else if (r < 93)
            return q_value;
        else if (r < 94)
            return q_value + 1;
        return random_word();
    endfunction

    function automatic bit random_done();
        return random_items >= RANDOM_ITEMS;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits of the register words carry junk; the block must ignore them
    task automatic set_q(input logic [CAND_W-1:0] q);
        logic [CFG_DATA_W-1:0] d;
        d = {$urandom(), $urandom()};
        d[HIGH_W-1:0] = q[CAND_W-1:LOW_W];
        write_reg(CFG_Q_LOW, q[LOW_W-1:0]);
        write_reg(CFG_Q_HIGH, d);
        q_value = q;
    endtask

    task automatic set_moduli(input logic [MOD_W-1:0] a, input logic [MOD_W-1:0] b,
                              input logic [MOD_W-1:0] c);
        write_reg(CFG_MODULUS_A, {$urandom(), a});
        write_reg(CFG_MODULUS_B, {$urandom(), b});
        write_reg(CFG_MODULUS_C, {$urandom(), c});
    endtask

    task automatic send_candidate(input logic [CAND_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 29) == 0)
                gap = $urandom_range(50, 200);
            else if ($urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 20);
            if (gap != 0)
            begin
                cand_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        cand_if.valid     <= 1'b1;
        cand_if.cand_low  <= word[LOW_W-1:0];
        cand_if.cand_high <= word[CAND_W-1:LOW_W];
        do
            @(posedge clk);
        while (!cand_if.ready);
    endtask

    // Dropped words leave no trace, so give the block time to finish after the last result
    task automatic wait_drained();
        cand_if.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 64)) @(posedge clk);
            res_if.ready <= 1'b0;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(100, 400)) @(posedge clk);
            else
                repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    initial
    begin
        int phase;
        int phase_len;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_Q_LOW;
        cfg_data          <= '0;
        cand_if.valid     <= 1'b0;
        cand_if.cand_low  <= '0;
        cand_if.cand_high <= '0;
        q_value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Q still zero after reset: every word is dropped
        send_candidate('0);
        send_candidate(CAND_MAX);
        send_candidate({17'h1, 64'h0});
        wait_drained();

        // Q at max, moduli still one; Q itself must be dropped
        set_q(CAND_MAX);
        send_candidate('0);
        send_candidate(CAND_MAX - 1);
        send_candidate(CAND_MAX);
        send_candidate({1'b1, 80'h0});
        wait_drained();

        // boundary around Q in both halves, zero modulus, max modulus
        set_moduli(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        set_q({17'h10000, 64'h8000_0000_0000_0000});
        send_candidate(q_value - 1);
        send_candidate(q_value);
        send_candidate(q_value + 1);
        send_candidate({17'h10000, 64'h0});
        send_candidate({17'h0FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        send_candidate({17'h10001, 64'h0});
        send_candidate('0);
        send_candidate(81'd1);
        wait_drained();

        set_moduli(32'd3, 32'd1, 32'hFFFF_FFFE);
        set_q(CAND_MAX);
        send_candidate(CAND_MAX - 1);
        send_candidate({17'h1FFFF, 64'h0});
        send_candidate({17'h0, 64'hFFFF_FFFF_FFFF_FFFF});
        send_candidate({17'h0AAAA, 64'h5555_5555_5555_5555});
        send_candidate({17'h15555, 64'hAAAA_AAAA_AAAA_AAAA});

        // random phases, each with fresh moduli and Q
        phase = 0;
        while (!random_done())
        begin
            wait_drained();
            set_moduli(pick_modulus(), pick_modulus(), pick_modulus());
            set_q(pick_q());
            if (phase == 1)
                long_hold_req = 1'b1;
            phase_len = $urandom_range(300, 700);
            for (int n = 0; n < phase_len && !random_done(); n++)
            begin
                if (phase == 2 && n == phase_len / 2)
                    wait_drained();
                send_candidate(pick_candidate());
                random_items++;
            end
            phase++;
        end

        wait_drained();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
